// ===== hdl/erl_pkg.sv =====
// erl_pkg: shared constants, types and the pair hash for the event rate limiter
// depends on nothing; imported by erl_div, event_rate_limiter, erl_decision_checker and event_rate_limiter_tb
`default_nettype none

package erl_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam bit SLOT_POW2  = ((SLOT_COUNT & (SLOT_COUNT - 1)) == 0);

  localparam int SHIFT_A = 13;
  localparam int SHIFT_B = 17;
  localparam int SHIFT_C = 5;

  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [1:0] POL_NONE     = 2'd0;
  localparam logic [1:0] POL_INTERVAL = 2'd1;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] last_pass;
    logic [31:0] last_refill;
    logic [15:0] tokens;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_ISSUE,
    ST_CHECK,
    ST_EVAL,
    ST_DIV,
    ST_SAT,
    ST_SPEND,
    ST_WRITE,
    ST_DONE
  } state_t;

  function automatic logic [31:0] pair_hash(input logic [31:0] ev, input logic [15:0] src);
    logic [31:0] x;
    x = ev ^ {src, 16'h0000};
    x = x ^ (x << SHIFT_A);
    x = x ^ (x >> SHIFT_B);
    x = x ^ (x << SHIFT_C);
    return x;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/erl_div.sv =====
// erl_div: restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit a cycle
// depends on erl_pkg
`default_nettype none

module erl_div
  import erl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [31:0]      quotient,
  output logic [15:0]      remainder
);

  logic [DIV_CNT_W-1:0] count;
  logic [15:0]          dsr;
  logic [16:0]          shifted;
  logic                 fits;

  assign shifted = {remainder, quotient[31]};
  assign fits    = (shifted >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= DIV_CNT_W'(DIV_STEPS);
      end else if (count != '0) begin
        count <= count - 1'b1;
        if (count == DIV_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr       <= divisor;
      quotient  <= dividend;
      remainder <= '0;
    end else if (count != '0) begin
      quotient <= {quotient[30:0], fits};
      if (fits) begin
        remainder <= 16'(shifted - {1'b0, dsr});
      end else begin
        remainder <= shifted[15:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/event_rate_limiter.sv =====
// event_rate_limiter: per event and source rate limiting with a hashed slot table
// depends on erl_pkg and erl_div
//
//   channel | handshake          | payload
//   in      | in_valid, in_stall | event_tag source_tag policy min_interval bucket_capacity
//           |                    | refill_period refill_amount now_time
//   out     | out_valid, out_stall | allowed table_full
//
// one word at a time: policy 0 goes straight to the result register without a table lookup
// each probe of the slot table takes an issue and a check state (one read port, registered read data)
// a bucket refill adds the 32-step serial divider, multiply and saturate
// a non power of two table first takes the slot index from the divider as hash mod SLOT_COUNT
// reset clears all slot in-use flags together, no clearing pass
// a finished word waits in the output register while out_stall is high
`default_nettype none

module event_rate_limiter
  import erl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] event_tag,
  input  wire logic [15:0] source_tag,
  input  wire logic [1:0]  policy,
  input  wire logic [15:0] min_interval,
  input  wire logic [15:0] bucket_capacity,
  input  wire logic [15:0] refill_period,
  input  wire logic [15:0] refill_amount,
  input  wire logic [31:0] now_time,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             allowed,
  output logic             table_full
);

  state_t state, state_next;

  logic [1:0]  pol;
  logic [15:0] mint, cap, per, amt;
  logic [31:0] now, hash;
  logic [IDX_W-1:0] idx, cnt;
  entry_t      ent;
  logic        allow_r, full_r;
  logic [31:0] el;
  logic [47:0] prod;

  logic [SLOT_COUNT-1:0] in_use;
  entry_t mem [SLOT_COUNT];
  entry_t rd_data;
  logic   rd_en, wr_en;

  logic        div_start, div_done;
  logic [31:0] div_a, div_quot;
  logic [15:0] div_b, div_rem;

  logic [31:0] hash_c;
  logic        in_acc, hit, bucket_on;
  logic [31:0] elapsed_c;
  logic [48:0] sum_c;

  assign hash_c    = pair_hash(event_tag, source_tag);
  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = rst || (state != ST_IDLE);
  assign hit       = !in_use[idx] || (rd_data.key == hash);
  assign bucket_on = (cap != '0) && (per != '0) && (amt != '0);
  assign elapsed_c = now - ent.last_refill;
  assign sum_c     = 49'(ent.tokens) + 49'(prod);

  erl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[idx];
    end
    if (wr_en) begin
      mem[idx] <= ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else if (wr_en) begin
      in_use[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    div_start  = 1'b0;
    div_a      = hash_c;
    div_b      = 16'(SLOT_COUNT);
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (policy == POL_NONE) begin
            state_next = ST_DONE;
          end else if (SLOT_POW2) begin
            state_next = ST_ISSUE;
          end else begin
            div_start  = 1'b1;
            state_next = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (div_done) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        rd_en      = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (hit) begin
          state_next = ST_EVAL;
        end else if (cnt == IDX_W'(SLOT_COUNT - 1)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_ISSUE;
        end
      end
      ST_EVAL: begin
        if (pol == POL_INTERVAL || !bucket_on) begin
          state_next = ST_WRITE;
        end else if (ent.last_refill == '0) begin
          state_next = ST_SPEND;
        end else if (elapsed_c >= 32'(per)) begin
          div_start  = 1'b1;
          div_a      = elapsed_c;
          div_b      = per;
          state_next = ST_DIV;
        end else begin
          state_next = ST_SPEND;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_SAT;
        end
      end
      ST_SAT:   state_next = ST_SPEND;
      ST_SPEND: state_next = ST_WRITE;
      ST_WRITE: begin
        wr_en      = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          pol     <= policy;
          mint    <= min_interval;
          cap     <= bucket_capacity;
          per     <= refill_period;
          amt     <= refill_amount;
          now     <= now_time;
          hash    <= hash_c;
          idx     <= IDX_W'(hash_c & 32'(SLOT_COUNT - 1));
          cnt     <= '0;
          allow_r <= 1'b1;
          full_r  <= 1'b0;
        end
      end
      ST_MOD: begin
        if (div_done) begin
          idx <= div_rem[IDX_W-1:0];
        end
      end
      ST_CHECK: begin
        if (!in_use[idx]) begin
          ent <= '{key: hash, last_pass: '0, last_refill: '0, tokens: '0};
        end else if (rd_data.key == hash) begin
          ent <= rd_data;
        end else if (cnt == IDX_W'(SLOT_COUNT - 1)) begin
          full_r <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
          if (idx == IDX_W'(SLOT_COUNT - 1)) begin
            idx <= '0;
          end else begin
            idx <= idx + 1'b1;
          end
        end
      end
      ST_EVAL: begin
        el <= elapsed_c;
        if (pol == POL_INTERVAL) begin
          if (mint != '0) begin
            if ((now - ent.last_pass) < 32'(mint)) begin
              allow_r <= 1'b0;
            end else begin
              ent.last_pass <= now;
            end
          end
        end else if (bucket_on && ent.last_refill == '0) begin
          ent.last_refill <= now;
          ent.tokens      <= cap;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          prod            <= 48'(div_quot) * 48'(amt);
          ent.last_refill <= ent.last_refill + (el - 32'(div_rem));
        end
      end
      ST_SAT: begin
        if (sum_c > 49'(cap)) begin
          ent.tokens <= cap;
        end else begin
          ent.tokens <= sum_c[15:0];
        end
      end
      ST_SPEND: begin
        if (ent.tokens == '0) begin
          allow_r <= 1'b0;
        end else begin
          ent.tokens <= ent.tokens - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || !out_stall)) begin
      allowed    <= allow_r;
      table_full <= full_r;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/erl_chk.sv =====
// erl_chk: port-level checks for event_rate_limiter, attached by bind
// depends on event_rate_limiter's port list
`default_nettype none

module erl_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        allowed,
  input wire logic        table_full
);

  // a held result word does not move
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(allowed) && $stable(table_full))
    else $error("result word changed while stalled");

  // a full table always lets the word through
  a_full_allows: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> allowed)
    else $error("table full but word suppressed");

  // one word in flight: input closes after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while one in flight");

  // a new result only appears from a busy cycle
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work");

endmodule

bind event_rate_limiter erl_chk u_erl_chk (.*);

`default_nettype wire

// ===== bench/erl_decision_checker.sv =====
// erl_decision_checker: watches both channels of event_rate_limiter, predicts each decision
// from its own copy of the slot table and compares every result word; hands back counts
// depends on erl_pkg for SLOT_COUNT and the policy codes
module erl_decision_checker
  import erl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [31:0] event_tag,
  input  wire logic [15:0] source_tag,
  input  wire logic [1:0]  policy,
  input  wire logic [15:0] min_interval,
  input  wire logic [15:0] bucket_capacity,
  input  wire logic [15:0] refill_period,
  input  wire logic [15:0] refill_amount,
  input  wire logic [31:0] now_time,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        allowed,
  input  wire logic        table_full,
  output int               errors,
  output int               pending
);

  typedef struct packed {
    logic allowed;
    logic table_full;
  } decision_t;

  localparam int MIX_A       = 13;
  localparam int MIX_B       = 17;
  localparam int MIX_C       = 5;

  logic        claimed      [SLOT_COUNT];
  logic [31:0] stored_key   [SLOT_COUNT];
  logic [31:0] pass_stamp   [SLOT_COUNT];
  logic [31:0] refill_stamp [SLOT_COUNT];
  logic [15:0] token_level  [SLOT_COUNT];
  decision_t   decisions_q  [$];
  int          result_no;

  function automatic logic [31:0] xorshift_key(input logic [31:0] ev, input logic [15:0] src);
    logic [31:0] x;
    x = {ev[31:16] ^ src, ev[15:0]};
    x = x ^ (x << MIX_A);
    x = x ^ (x >> MIX_B);
    x = x ^ (x << MIX_C);
    return x;
  endfunction

  // linear probe from key mod table size; returns the slot holding the key or claims the first free slot
  function automatic int claim_slot(input logic [31:0] key);
    int idx;
    idx = int'(key % SLOT_COUNT);
    for (int n = 0; n < SLOT_COUNT; n++) begin
      if (!claimed[idx]) begin
        claimed[idx]      = 1'b1;
        stored_key[idx]   = key;
        pass_stamp[idx]   = '0;
        refill_stamp[idx] = '0;
        token_level[idx]  = '0;
        return idx;
      end
      if (stored_key[idx] == key) return idx;
      idx = (idx + 1) % SLOT_COUNT;
    end
    return -1;
  endfunction

  function automatic decision_t judge_request(
    input logic [31:0] ev,
    input logic [15:0] src,
    input logic [1:0]  pol,
    input logic [15:0] mint,
    input logic [15:0] cap,
    input logic [15:0] per,
    input logic [15:0] amt,
    input logic [31:0] now
  );
    decision_t   d;
    int          s;
    logic [31:0] elapsed;
    logic [31:0] steps;
    logic [63:0] refilled;
    d.allowed    = 1'b1;
    d.table_full = 1'b0;
    if (pol != POL_NONE) begin
      s = claim_slot(xorshift_key(ev, src));
      if (s < 0) begin
        d.table_full = 1'b1;
      end else if (pol == POL_INTERVAL) begin
        if (mint != 16'd0) begin
          elapsed = now - pass_stamp[s];
          if (elapsed < {16'h0, mint}) begin
            d.allowed = 1'b0;
          end else begin
            pass_stamp[s] = now;
          end
        end
      end else if (cap != 16'd0 && per != 16'd0 && amt != 16'd0) begin
        // zero stamp means the bucket has never been filled
        if (refill_stamp[s] == 32'd0) begin
          refill_stamp[s] = now;
          token_level[s]  = cap;
        end else begin
          elapsed = now - refill_stamp[s];
          if (elapsed >= {16'h0, per}) begin
            steps    = elapsed / {16'h0, per};
            refilled = {48'h0, token_level[s]} + {32'h0, steps} * {48'h0, amt};
            token_level[s]  = (refilled > {48'h0, cap}) ? cap : refilled[15:0];
            refill_stamp[s] = refill_stamp[s] + steps * {16'h0, per};
          end
        end
        if (token_level[s] == 16'd0) begin
          d.allowed = 1'b0;
        end else begin
          token_level[s] = token_level[s] - 16'd1;
        end
      end
    end
    return d;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t erl check: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    decision_t want;
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        claimed[i]      = 1'b0;
        stored_key[i]   = '0;
        pass_stamp[i]   = '0;
        refill_stamp[i] = '0;
        token_level[i]  = '0;
      end
      decisions_q.delete();
      result_no = 0;
      errors    = 0;
    end else begin
      // retire before accepting: a word never leaves in the cycle it arrives
      if (out_valid && !out_stall) begin
        if (decisions_q.size() == 0) begin
          report_mismatch($sformatf("result word %0d with no request outstanding", result_no));
        end else begin
          want = decisions_q.pop_front();
          if (allowed !== want.allowed)
            report_mismatch($sformatf("word %0d allowed %b, predicted %b",
                                      result_no, allowed, want.allowed));
          if (table_full !== want.table_full)
            report_mismatch($sformatf("word %0d table_full %b, predicted %b",
                                      result_no, table_full, want.table_full));
        end
        result_no++;
      end
      if (in_valid && !in_stall)
        decisions_q.push_back(judge_request(event_tag, source_tag, policy, min_interval,
                                            bucket_capacity, refill_period, refill_amount,
                                            now_time));
    end
    pending = decisions_q.size();
  end

endmodule

// ===== bench/event_rate_limiter_tb.sv =====
// event_rate_limiter_tb: drives directed and random event posts into event_rate_limiter
// with random gaps and output stalls, and gives the verdict from erl_decision_checker
// depends on erl_pkg, event_rate_limiter and erl_decision_checker
module event_rate_limiter_tb;
  import erl_pkg::*;

  localparam logic [1:0] POL_BUCKET   = 2'd2;
  localparam logic [1:0] POL_SPARE    = 2'd3;
  localparam int         RANDOM_POSTS = 1650;
  localparam int         POOL_SIZE    = 24;
  localparam int         DRAIN_CYCLES = 2 * SLOT_COUNT + 64;

  typedef struct {
    logic [31:0] ev;
    logic [15:0] src;
    logic [1:0]  pol;
    logic [15:0] mint;
    logic [15:0] cap;
    logic [15:0] per;
    logic [15:0] amt;
    logic [31:0] now;
  } event_post_t;

  logic        clk             = 1'b0;
  logic        rst             = 1'b1;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [31:0] event_tag       = '0;
  logic [15:0] source_tag      = '0;
  logic [1:0]  policy          = POL_NONE;
  logic [15:0] min_interval    = '0;
  logic [15:0] bucket_capacity = '0;
  logic [15:0] refill_period   = '0;
  logic [15:0] refill_amount   = '0;
  logic [31:0] now_time        = '0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic        allowed;
  logic        table_full;
  int          errors;
  int          pending;
  int          gap_mode        = 0;
  int          stall_mode      = 0;
  int          stall_left      = 0;

  event_rate_limiter i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .event_tag       (event_tag),
    .source_tag      (source_tag),
    .policy          (policy),
    .min_interval    (min_interval),
    .bucket_capacity (bucket_capacity),
    .refill_period   (refill_period),
    .refill_amount   (refill_amount),
    .now_time        (now_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .allowed         (allowed),
    .table_full      (table_full)
  );

  erl_decision_checker i_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .event_tag       (event_tag),
    .source_tag      (source_tag),
    .policy          (policy),
    .min_interval    (min_interval),
    .bucket_capacity (bucket_capacity),
    .refill_period   (refill_period),
    .refill_amount   (refill_amount),
    .now_time        (now_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .allowed         (allowed),
    .table_full      (table_full),
    .errors          (errors),
    .pending         (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // mode 0 never idles, 1 short gaps, 2 short gaps with the odd long one
  function automatic int pick_gap(input int mode);
    if (mode == 0) return 0;
    if ($urandom_range(0, 3) != 0) return 0;
    if (mode == 2 && $urandom_range(0, 7) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      stall_left = pick_gap(stall_mode);
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  function automatic event_post_t make_post(
    input logic [31:0] ev,
    input logic [15:0] src,
    input logic [1:0]  pol,
    input logic [15:0] mint,
    input logic [15:0] cap,
    input logic [15:0] per,
    input logic [15:0] amt,
    input logic [31:0] now
  );
    event_post_t p;
    p.ev   = ev;
    p.src  = src;
    p.pol  = pol;
    p.mint = mint;
    p.cap  = cap;
    p.per  = per;
    p.amt  = amt;
    p.now  = now;
    return p;
  endfunction

  task automatic post_event(input event_post_t p);
    int gap;
    in_valid        <= 1'b1;
    event_tag       <= p.ev;
    source_tag      <= p.src;
    policy          <= p.pol;
    min_interval    <= p.mint;
    bucket_capacity <= p.cap;
    refill_period   <= p.per;
    refill_amount   <= p.amt;
    now_time        <= p.now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = pick_gap(gap_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_directed();
    logic [31:0] ev_a, ev_b, ev_bx, ev_c, ev_d;
    logic [15:0] src_a, src_b, src_bx, src_c, src_d;
    ev_a   = 32'h0000_0000;
    src_a  = 16'h0000;
    ev_b   = 32'h1234_5678;
    src_b  = 16'h00A5;
    // same hash as the b pair: shares its slot
    ev_bx  = ev_b ^ 32'h5A5A_0000;
    src_bx = src_b ^ 16'h5A5A;
    ev_c   = 32'hDEAD_BEEF;
    src_c  = 16'hFFFF;
    ev_d   = 32'h8000_0001;
    src_d  = 16'h8001;
    gap_mode   = 1;
    stall_mode = 2;
    post_event(make_post(32'hFFFF_FFFF, 16'hFFFF, POL_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 32'hFFFF_FFFF));
    post_event(make_post(ev_a, src_a, POL_INTERVAL, 16'd100, 16'd0, 16'd0, 16'd0, 32'd50));
    post_event(make_post(ev_a, src_a, POL_INTERVAL, 16'd100, 16'd0, 16'd0, 16'd0, 32'd100));
    post_event(make_post(ev_a, src_a, POL_INTERVAL, 16'd100, 16'd0, 16'd0, 16'd0, 32'd199));
    post_event(make_post(ev_a, src_a, POL_INTERVAL, 16'd0, 16'd0, 16'd0, 16'd0, 32'd199));
    post_event(make_post(ev_a, src_a, POL_INTERVAL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         32'hFFFF_FFFF));
    // bucket filled at time zero stays unset
    post_event(make_post(ev_b, src_b, POL_BUCKET, 16'd0, 16'd2, 16'd10, 16'd1, 32'd0));
    post_event(make_post(ev_b, src_b, POL_BUCKET, 16'd0, 16'd2, 16'd10, 16'd1, 32'd5));
    post_event(make_post(ev_b, src_b, POL_BUCKET, 16'd0, 16'd2, 16'd10, 16'd1, 32'd6));
    post_event(make_post(ev_b, src_b, POL_BUCKET, 16'd0, 16'd2, 16'd10, 16'd1, 32'd7));
    post_event(make_post(ev_b, src_b, POL_BUCKET, 16'd0, 16'd2, 16'd10, 16'd1, 32'd25));
    post_event(make_post(ev_b, src_b, POL_BUCKET, 16'd0, 16'd0, 16'd10, 16'd1, 32'd26));
    post_event(make_post(ev_b, src_b, POL_BUCKET, 16'd0, 16'd2, 16'd0, 16'd1, 32'd26));
    post_event(make_post(ev_b, src_b, POL_BUCKET, 16'd0, 16'd2, 16'd10, 16'd0, 32'd26));
    post_event(make_post(ev_bx, src_bx, POL_BUCKET, 16'd0, 16'd2, 16'd10, 16'd1, 32'd26));
    post_event(make_post(ev_bx, src_bx, POL_BUCKET, 16'd0, 16'd2, 16'd10, 16'd1, 32'd27));
    // refill stamp wraps to zero and the bucket counts as unset again
    post_event(make_post(ev_c, src_c, POL_SPARE, 16'd0, 16'hFFFF, 16'd16, 16'hFFFF,
                         32'hFFFF_FFF0));
    post_event(make_post(ev_c, src_c, POL_SPARE, 16'd0, 16'hFFFF, 16'd16, 16'hFFFF, 32'd0));
    post_event(make_post(ev_c, src_c, POL_SPARE, 16'd0, 16'hFFFF, 16'd16, 16'hFFFF, 32'd3));
    // huge refill saturates at capacity
    post_event(make_post(ev_d, src_d, POL_BUCKET, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF, 32'd1000));
    post_event(make_post(ev_d, src_d, POL_BUCKET, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF,
                         32'hFFFF_FFFF));
    post_event(make_post(ev_d, src_d, POL_BUCKET, 16'd0, 16'd1, 16'hFFFF, 16'd1,
                         32'hFFFF_FFFF));
    post_event(make_post(ev_a, src_a, POL_NONE, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0));
  endtask

  task automatic run_random();
    event_post_t pool [POOL_SIZE];
    event_post_t p;
    logic [31:0] clock_ms;
    logic [15:0] d;
    int          k;
    int          last_k;
    int          r;
    // start just short of the wrap so time passes through zero early on
    clock_ms = 32'hFFFF_FF00;
    last_k   = 0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i % 4 == 3) begin
        d           = 16'($urandom_range(1, 65535));
        pool[i]     = pool[i-1];
        pool[i].ev  = pool[i-1].ev ^ {d, 16'h0000};
        pool[i].src = pool[i-1].src ^ d;
      end else begin
        pool[i].ev   = $urandom;
        pool[i].src  = 16'($urandom);
        r            = $urandom_range(0, 9);
        pool[i].pol  = (r == 0) ? POL_NONE : (r < 5) ? POL_INTERVAL :
                       (r < 9) ? POL_BUCKET : POL_SPARE;
        pool[i].mint = 16'($urandom_range(1, 300));
        pool[i].cap  = 16'($urandom_range(1, 6));
        pool[i].per  = 16'($urandom_range(1, 200));
        pool[i].amt  = 16'($urandom_range(1, 3));
        pool[i].now  = '0;
      end
    end
    for (int n = 0; n < RANDOM_POSTS; n++) begin
      if (n % 200 == 0) begin
        gap_mode   = (n / 200) % 3;
        stall_mode = (n / 200 + 1 + n / 600) % 3;
      end
      r = $urandom_range(0, 99);
      if (r < 80) begin
        // bursts on one pair drain its bucket and hit its interval
        k      = ($urandom_range(0, 9) < 3) ? last_k : $urandom_range(0, POOL_SIZE - 1);
        last_k = k;
        p      = pool[k];
        if ($urandom_range(0, 19) == 0) p.pol = 2'($urandom);
        if ($urandom_range(0, 9) == 0) p.mint = 16'($urandom);
        if ($urandom_range(0, 9) == 0) p.cap = 16'($urandom);
        if ($urandom_range(0, 9) == 0) p.per = 16'($urandom);
        if ($urandom_range(0, 9) == 0) p.amt = 16'($urandom);
      end else begin
        p.ev  = $urandom;
        p.src = 16'($urandom);
        p.pol = 2'($urandom);
        if ($urandom_range(0, 3) == 0) begin
          p.mint = 16'($urandom);
          p.cap  = 16'($urandom);
          p.per  = 16'($urandom);
          p.amt  = 16'($urandom);
        end else begin
          p.mint = 16'($urandom_range(0, 300));
          p.cap  = 16'($urandom_range(0, 6));
          p.per  = 16'($urandom_range(0, 200));
          p.amt  = 16'($urandom_range(0, 3));
        end
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        clock_ms = clock_ms + $urandom;
      end else begin
        clock_ms = clock_ms + 32'($urandom_range(0, 3));
      end
      p.now = (r >= 97) ? $urandom : clock_ms;
      post_event(p);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
